>>> rtl/core/mkd_pkg.sv
//------------------------------------------------------------------------------
// mkd_pkg
// Types, constants and the Morse lookup function for the keying decoder.
//------------------------------------------------------------------------------
`default_nettype none
package mkd_pkg;

   localparam int UNIT_W = 24;

   typedef enum logic [1:0] {
      KIND_CHAR   = 2'd0,
      KIND_SPACE  = 2'd1,
      KIND_EXPIRE = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CSR_HOP_TIME  = 2'd0,
      CSR_DEBOUNCE  = 2'd1,
      CSR_GLITCH    = 2'd2,
      CSR_IDLE_LIM  = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MARK_MUL,
      ST_MARK_TRACK,
      ST_WPM_MUL,
      ST_WPM_DIV,
      ST_WPM_END,
      ST_GAP,
      ST_GAP_TRACK,
      ST_IDLE_ACCT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       start;
      logic [5:0] steps;
   } div_ctl_type;

   function automatic logic [6:0] morse_lookup(input logic [6:0] bits,
                                               input logic [2:0] len);
      logic [6:0] c;
      c = 7'd0;
      case ({len, bits})
         {3'd2, 7'b0000001}: c = 7'h41;
         {3'd4, 7'b0001000}: c = 7'h42;
         {3'd4, 7'b0001010}: c = 7'h43;
         {3'd3, 7'b0000100}: c = 7'h44;
         {3'd1, 7'b0000000}: c = 7'h45;
         {3'd4, 7'b0000010}: c = 7'h46;
         {3'd3, 7'b0000110}: c = 7'h47;
         {3'd4, 7'b0000000}: c = 7'h48;
         {3'd2, 7'b0000000}: c = 7'h49;
         {3'd4, 7'b0000111}: c = 7'h4A;
         {3'd3, 7'b0000101}: c = 7'h4B;
         {3'd4, 7'b0000100}: c = 7'h4C;
         {3'd2, 7'b0000011}: c = 7'h4D;
         {3'd2, 7'b0000010}: c = 7'h4E;
         {3'd3, 7'b0000111}: c = 7'h4F;
         {3'd4, 7'b0000110}: c = 7'h50;
         {3'd4, 7'b0001101}: c = 7'h51;
         {3'd3, 7'b0000010}: c = 7'h52;
         {3'd3, 7'b0000000}: c = 7'h53;
         {3'd1, 7'b0000001}: c = 7'h54;
         {3'd3, 7'b0000001}: c = 7'h55;
         {3'd4, 7'b0000001}: c = 7'h56;
         {3'd3, 7'b0000011}: c = 7'h57;
         {3'd4, 7'b0001001}: c = 7'h58;
         {3'd4, 7'b0001011}: c = 7'h59;
         {3'd4, 7'b0001100}: c = 7'h5A;
         {3'd5, 7'b0011111}: c = 7'h30;
         {3'd5, 7'b0001111}: c = 7'h31;
         {3'd5, 7'b0000111}: c = 7'h32;
         {3'd5, 7'b0000011}: c = 7'h33;
         {3'd5, 7'b0000001}: c = 7'h34;
         {3'd5, 7'b0000000}: c = 7'h35;
         {3'd5, 7'b0010000}: c = 7'h36;
         {3'd5, 7'b0011000}: c = 7'h37;
         {3'd5, 7'b0011100}: c = 7'h38;
         {3'd5, 7'b0011110}: c = 7'h39;
         {3'd5, 7'b0010010}: c = 7'h2F;
         {3'd6, 7'b0110011}: c = 7'h2C;
         {3'd6, 7'b0010101}: c = 7'h2E;
         {3'd6, 7'b0001100}: c = 7'h3F;
         {3'd5, 7'b0010001}: c = 7'h3D;
         {3'd5, 7'b0001010}: c = 7'h2B;
         {3'd5, 7'b0010110}: c = 7'h28;
         default:            c = 7'd0;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/mkd_divider.sv
//------------------------------------------------------------------------------
// mkd_divider
// Restoring divider, one quotient bit per cycle, for the unit trackers and
// the speed estimate.
//------------------------------------------------------------------------------
`default_nettype none
module mkd_divider
   import mkd_pkg::*;
#(
   parameter int W = 48
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire div_ctl_type  ctl,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic              busy,
   output logic [W-1:0]      quotient
);

   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] quo_ff, quo_in;
   logic [W-1:0] den_ff, den_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic [W:0]   trial;
   logic [W:0]   shifted;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      shifted = {rem_ff, quo_ff[W-1]};
      trial   = shifted - {1'b0, den_ff};
      if (ctl.start) begin
         rem_in = '0;
         quo_in = dividend;
         den_in = divisor;
         cnt_in = ctl.steps;
      end else if (cnt_ff != 6'd0) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 6'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy     = (cnt_ff != 6'd0);
   assign quotient = quo_ff;

endmodule
`default_nettype wire

>>> rtl/core/morse_keying_decoder.sv
//------------------------------------------------------------------------------
// morse_keying_decoder
// Adaptive Morse keying decoder for one carrier, one item per hop.
//------------------------------------------------------------------------------
// channel  direction  handshake        payload
// req      in         valid / stall    level, noise_floor
// rsp      out        valid / stall    kind, char_code, speed_wpm, last
// csr      in         write enable     index, data (16 bits)
//
// The input is stalled while an item is in progress; a mark runs up to two
// 48-step passes of the bit-serial divider (unit tracker, then speed
// estimate), a gap up to one tracker pass and up to two results.
// Reset is synchronous and clears the control and tracking state; CSR regs
// return to their defaults. Result stall holds the sequencer at the emit step.
//------------------------------------------------------------------------------
`default_nettype none
module morse_keying_decoder
   import mkd_pkg::*;
#(
   parameter int UNIT_FRAC_BITS = 8,
   parameter int MAX_SYMBOL_LEN = 7,
   parameter int LEVEL_BITS     = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [LEVEL_BITS-1:0] req_level,
   input  wire logic [LEVEL_BITS-1:0] req_noise_floor,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [1:0]                 rsp_kind,
   output logic [6:0]                 rsp_char_code,
   output logic [6:0]                 rsp_speed_wpm,
   output logic                       rsp_last,
   input  wire logic                  csr_write,
   input  wire logic [1:0]            csr_index,
   input  wire logic [15:0]           csr_data
);

   localparam int DW = 48;
   localparam logic [UNIT_W-1:0] UNIT_MAX = {UNIT_W{1'b1}};
   localparam logic [DW-1:0] ONE = DW'(1) << (UNIT_FRAC_BITS + 9);

   logic [15:0] hop_time_ff;
   logic [3:0]  debounce_ff;
   logic [4:0]  glitch_ff;
   logic [15:0] idle_lim_ff;

   state_type   state_ff, state_in;
   logic        raw_down_ff, raw_down_in;
   logic        key_down_ff, key_down_in;
   logic [3:0]  pend_ff, pend_in;
   logic [15:0] run_ff, run_in;
   logic [UNIT_W-1:0] mark_ff, mark_in;
   logic [UNIT_W-1:0] gapu_ff, gapu_in;
   logic [6:0]  sym_ff, sym_in;
   logic [2:0]  slen_ff, slen_in;
   logic [15:0] idle_ff, idle_in;
   logic [6:0]  wpm_ff, wpm_in;
   logic        started_ff, started_in;
   logic        lspace_ff, lspace_in;

   logic [UNIT_W-1:0] dq_ff, dq_in;
   logic [15:0] dur_ff, dur_in;
   logic        dah_ff, dah_in;
   logic [DW-1:0] acc_ff, acc_in;

   logic [1:0]  n_ff, n_in;
   logic [1:0]  okind_ff [2];
   logic [6:0]  ochar_ff [2];
   logic [6:0]  owpm_ff  [2];
   logic [1:0]  okind_in [2];
   logic [6:0]  ochar_in [2];
   logic [6:0]  owpm_in  [2];
   logic        osel_ff, osel_in;
   logic        track_up_ff, track_up_in;

   div_ctl_type   dctl;
   logic [DW-1:0] dnum, dden, dquo;
   logic          dbusy;

   mkd_divider #(.W(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (dctl),
      .dividend (dnum),
      .divisor  (dden),
      .busy     (dbusy),
      .quotient (dquo)
   );

   logic [LEVEL_BITS+3:0] lv2, fl9, fl5;
   logic [15:0] run_inc, dur_c;
   logic [3:0]  pend_inc;
   logic [UNIT_W+15:0] dq_wide;
   logic [UNIT_W-1:0]  gu;
   logic [UNIT_W+3:0]  dq5, gu9, gu2, gu6;
   logic [UNIT_W:0]    s_sum;
   logic [6:0]  ch;

   always_comb begin
      lv2      = {3'd0, req_level, 1'b0};
      fl9      = {4'd0, req_noise_floor} + {1'b0, req_noise_floor, 3'd0};
      fl5      = {4'd0, req_noise_floor} + {2'd0, req_noise_floor, 2'd0};
      run_inc  = (run_ff != 16'hFFFF) ? run_ff + 16'd1 : run_ff;
      pend_inc = (pend_ff != 4'hF) ? pend_ff + 4'd1 : pend_ff;
      dur_c    = (run_inc > {12'd0, pend_inc}) ? run_inc - {12'd0, pend_inc} : 16'd1;
      dq_wide  = {{UNIT_W{1'b0}}, dur_c} << UNIT_FRAC_BITS;
      gu       = (gapu_ff != '0) ? gapu_ff : mark_ff;
      dq5      = {4'd0, dq_ff} + {2'd0, dq_ff, 2'd0};
      gu9      = {4'd0, gu} + {1'b0, gu, 3'd0};
      gu2      = {3'd0, gu, 1'b0};
      gu6      = {3'd0, gu, 1'b0} + {2'd0, gu, 2'd0};
      s_sum    = {1'b0, mark_ff} + {1'b0, gu};
      ch       = morse_lookup(sym_ff, slen_ff);
   end

   always_comb begin
      state_in    = state_ff;
      raw_down_in = raw_down_ff;
      key_down_in = key_down_ff;
      pend_in     = pend_ff;
      run_in      = run_ff;
      mark_in     = mark_ff;
      gapu_in     = gapu_ff;
      sym_in      = sym_ff;
      slen_in     = slen_ff;
      idle_in     = idle_ff;
      wpm_in      = wpm_ff;
      started_in  = started_ff;
      lspace_in   = lspace_ff;
      dq_in       = dq_ff;
      dur_in      = dur_ff;
      dah_in      = dah_ff;
      acc_in      = acc_ff;
      n_in        = n_ff;
      okind_in    = okind_ff;
      ochar_in    = ochar_ff;
      owpm_in     = owpm_ff;
      osel_in     = osel_ff;
      track_up_in = track_up_ff;
      dctl.start  = 1'b0;
      dctl.steps  = 6'd0;
      dnum        = '0;
      dden        = '0;
      req_stall   = (state_ff != ST_IDLE);
      rsp_valid   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               n_in = 2'd0;
               osel_in = 1'b0;
               if (!raw_down_ff && lv2 > fl9) raw_down_in = 1'b1;
               else if (raw_down_ff && lv2 < fl5) raw_down_in = 1'b0;
               run_in = run_inc;
               state_in = ST_IDLE_ACCT;
               if (raw_down_in != key_down_ff) begin
                  pend_in = pend_inc;
                  if (pend_inc >= debounce_ff) begin
                     dur_in = dur_c;
                     dq_in  = (dq_wide > {16'd0, UNIT_MAX}) ? UNIT_MAX : dq_wide[UNIT_W-1:0];
                     key_down_in = raw_down_in;
                     run_in = {12'd0, pend_inc};
                     pend_in = 4'd0;
                     if (key_down_ff) begin
                        if (dur_c < {11'd0, glitch_ff}) state_in = ST_EMIT;
                        else state_in = ST_MARK_MUL;
                     end else if (mark_ff != '0) begin
                        state_in = ST_GAP;
                     end
                  end
               end else begin
                  pend_in = 4'd0;
               end
            end
         end
         ST_MARK_MUL: begin
            dah_in = (mark_ff != '0) && (dq5 > {4'd0, mark_ff} + {1'b0, mark_ff, 3'd0});
            state_in = ST_WPM_MUL;
            if (!(mark_ff != '0 && dq5 > {4'd0, mark_ff} + {1'b0, mark_ff, 3'd0})) begin
               if (mark_ff == '0) begin
                  mark_in = dq_ff;
               end else begin
                  dctl.start = 1'b1;
                  dctl.steps = 6'(DW);
                  track_up_in = (dq_ff >= mark_ff);
                  if (dq_ff < mark_ff) begin
                     dnum = DW'({(mark_ff - dq_ff), 1'b0}) + DW'(2);
                     dden = DW'(5);
                  end else begin
                     dnum = DW'(dq_ff - mark_ff) + DW'(25);
                     dden = DW'(50);
                  end
                  state_in = ST_MARK_TRACK;
               end
            end
            if (slen_ff >= 3'(MAX_SYMBOL_LEN)) begin
               slen_in = 3'd7;
            end else begin
               sym_in  = {sym_ff[5:0], dah_in};
               slen_in = slen_ff + 3'd1;
            end
         end
         ST_MARK_TRACK: begin
            if (!dbusy && !dctl.start) begin
               mark_in = track_up_ff ? mark_ff + dquo[UNIT_W-1:0]
                                     : mark_ff - dquo[UNIT_W-1:0];
               state_in = ST_WPM_MUL;
            end
         end
         ST_WPM_MUL: begin
            acc_in = DW'(s_sum) * DW'(hop_time_ff);
            state_in = ST_WPM_DIV;
         end
         ST_WPM_DIV: begin
            if (acc_ff < ONE) begin
               wpm_in = 7'd80;
               state_in = ST_IDLE_ACCT;
            end else begin
               dctl.start = 1'b1;
               dctl.steps = 6'(DW);
               dnum = (ONE * DW'(2400)) + acc_ff;
               dden = {acc_ff[DW-2:0], 1'b0};
               state_in = ST_WPM_END;
            end
         end
         ST_WPM_END: begin
            if (!dbusy && !dctl.start) begin
               if (dquo < DW'(5)) wpm_in = 7'd5;
               else if (dquo > DW'(80)) wpm_in = 7'd80;
               else wpm_in = dquo[6:0];
               state_in = ST_IDLE_ACCT;
            end
         end
         ST_GAP: begin
            state_in = ST_IDLE_ACCT;
            if ({4'd0, dq_ff} >= gu2 && slen_ff != 3'd0) begin
               if (ch != 7'd0) begin
                  okind_in[0] = KIND_CHAR;
                  ochar_in[0] = ch;
                  owpm_in[0]  = wpm_ff;
                  n_in = 2'd1;
                  started_in = 1'b1;
                  lspace_in = 1'b0;
               end
               sym_in = 7'd0;
               slen_in = 3'd0;
               idle_in = 16'd0;
            end
            if ({4'd0, dq_ff} >= gu6 && started_in && !lspace_in) begin
               okind_in[n_in[0]] = KIND_SPACE;
               ochar_in[n_in[0]] = 7'd32;
               owpm_in[n_in[0]]  = wpm_ff;
               n_in = n_in + 2'd1;
               lspace_in = 1'b1;
            end
            if (dq5 < gu9 && dur_ff >= {11'd0, glitch_ff}) begin
               if (gapu_ff == '0) begin
                  gapu_in = dq_ff;
               end else begin
                  dctl.start = 1'b1;
                  dctl.steps = 6'(DW);
                  track_up_in = (dq_ff >= gapu_ff);
                  if (dq_ff < gapu_ff) begin
                     dnum = DW'({(gapu_ff - dq_ff), 1'b0}) + DW'(2);
                     dden = DW'(5);
                  end else begin
                     dnum = DW'(dq_ff - gapu_ff) + DW'(25);
                     dden = DW'(50);
                  end
                  state_in = ST_GAP_TRACK;
               end
            end else if (gapu_ff == '0 && dur_ff >= {11'd0, glitch_ff}) begin
               gapu_in = dq_ff;
            end
         end
         ST_GAP_TRACK: begin
            if (!dbusy && !dctl.start) begin
               gapu_in = track_up_ff ? gapu_ff + dquo[UNIT_W-1:0]
                                     : gapu_ff - dquo[UNIT_W-1:0];
               state_in = ST_IDLE_ACCT;
            end
         end
         ST_IDLE_ACCT: begin
            state_in = ST_EMIT;
            if (!key_down_ff && slen_ff == 3'd0) begin
               if (idle_ff != 16'hFFFF) idle_in = idle_ff + 16'd1;
            end else begin
               idle_in = 16'd0;
            end
            if (idle_in > idle_lim_ff && n_ff != 2'd2) begin
               okind_in[n_ff[0]] = KIND_EXPIRE;
               ochar_in[n_ff[0]] = 7'd0;
               owpm_in[n_ff[0]]  = wpm_ff;
               n_in = n_ff + 2'd1;
               raw_down_in = 1'b0;
               key_down_in = 1'b0;
               pend_in = 4'd0;
               run_in = 16'd0;
               mark_in = '0;
               gapu_in = '0;
               sym_in = 7'd0;
               slen_in = 3'd0;
               idle_in = 16'd0;
               wpm_in = 7'd0;
               started_in = 1'b0;
               lspace_in = 1'b0;
            end
         end
         ST_EMIT: begin
            if (n_ff == 2'd0 || {1'b0, osel_ff} >= n_ff) begin
               state_in = ST_IDLE;
            end else begin
               rsp_valid = 1'b1;
               if (!rsp_stall) begin
                  osel_in = 1'b1;
                  if ({1'b0, osel_ff} + 2'd1 >= n_ff) state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_kind      = okind_ff[osel_ff];
   assign rsp_char_code = ochar_ff[osel_ff];
   assign rsp_speed_wpm = owpm_ff[osel_ff];
   assign rsp_last      = ({1'b0, osel_ff} + 2'd1 == n_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         hop_time_ff <= 16'd683;
         debounce_ff <= 4'd2;
         glitch_ff   <= 5'd6;
         idle_lim_ff <= 16'd1875;
         raw_down_ff <= 1'b0;
         key_down_ff <= 1'b0;
         pend_ff     <= 4'd0;
         run_ff      <= 16'd0;
         mark_ff     <= '0;
         gapu_ff     <= '0;
         sym_ff      <= 7'd0;
         slen_ff     <= 3'd0;
         idle_ff     <= 16'd0;
         wpm_ff      <= 7'd0;
         started_ff  <= 1'b0;
         lspace_ff   <= 1'b0;
         n_ff        <= 2'd0;
         osel_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         raw_down_ff <= raw_down_in;
         key_down_ff <= key_down_in;
         pend_ff     <= pend_in;
         run_ff      <= run_in;
         mark_ff     <= mark_in;
         gapu_ff     <= gapu_in;
         sym_ff      <= sym_in;
         slen_ff     <= slen_in;
         idle_ff     <= idle_in;
         wpm_ff      <= wpm_in;
         started_ff  <= started_in;
         lspace_ff   <= lspace_in;
         n_ff        <= n_in;
         osel_ff     <= osel_in;
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_HOP_TIME: hop_time_ff <= csr_data;
               CSR_DEBOUNCE: debounce_ff <= csr_data[3:0];
               CSR_GLITCH:   glitch_ff   <= csr_data[4:0];
               CSR_IDLE_LIM: idle_lim_ff <= csr_data;
               default:      hop_time_ff <= hop_time_ff;
            endcase
         end
      end
      dq_ff       <= dq_in;
      dur_ff      <= dur_in;
      dah_ff      <= dah_in;
      acc_ff      <= acc_in;
      okind_ff    <= okind_in;
      ochar_ff    <= ochar_in;
      owpm_ff     <= owpm_in;
      track_up_ff <= track_up_in;
   end

endmodule
`default_nettype wire
